// ===== rtl/dcsl_pkg.sv =====
// ----------------------------------------------------------------------------
// dcsl_pkg: shared definitions for the distributed clock sync loop
// Field widths, register map, reset values, sequencer states and default
// parameter values used by the sync loop top level.
// ----------------------------------------------------------------------------
package dcsl_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Field widths
    localparam int CYCLE_W   = 30;
    localparam int PHASE_W   = 30;
    localparam int GAIN_W    = 16;
    localparam int DIFF_W    = 32;
    localparam int ERR_W     = 31;
    localparam int DERR_W    = 32;
    localparam int INTEG_W   = 32;
    localparam int STEP_W    = 48;
    localparam int BASE_W    = 64;
    localparam int ACC_W     = 52;
    localparam int PROD_W    = GAIN_W + DIFF_W;
    localparam int DIVISOR_W = 30;
    localparam int M_TDATA_W = 144;

    // Register reset values
    localparam logic [CYCLE_W-1:0] CYCLE_RST  = CYCLE_W'(2000000);
    localparam logic [PHASE_W-1:0] TARGET_RST = PHASE_W'(1000000);

    // Default parameter values
    localparam int AVERAGE_DEPTH_DEF = 16;
    localparam int DRIFT_WINDOW_DEF  = 512;
    localparam int IGNORE_ITEMS_DEF  = 20;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_CYCLE  = 3'd0,
        REG_TARGET = 3'd1,
        REG_KP     = 3'd2,
        REG_KI     = 3'd3,
        REG_KD     = 3'd4
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_FOLD_RUN,
        S_FOLD_END,
        S_SUM,
        S_AVG_RUN,
        S_ERR,
        S_UPD,
        S_DR_PREP,
        S_DR_LOAD,
        S_DR_RUN,
        S_DR_END,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_SAT,
        S_BASE,
        S_PUSH
    } t_state;

endpackage

// ===== rtl/distributed_clock_sync_loop.sv =====
// ----------------------------------------------------------------------------
// distributed_clock_sync_loop: bus clock follower with phase PID loop
// Folds each clock difference into one bus cycle, averages the phase over a
// ring of recent samples and adds a PID correction plus a periodic drift
// average to a 64-bit time base.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 32-bit clock difference per transfer (local minus
//   reference). Master stream: one result per input: phase error, base step
//   and time base in tdata, the startup flag in tuser.
//   One item is processed at a time. A processed item runs the fold
//   division, the ring update, the error and update steps, the multiply
//   and sum steps and the output push; an ignored startup item skips the
//   six multiply and sum steps. A non power of two depth adds the
//   averaging division. Once every DRIFT_WINDOW processed items the drift
//   term adds its prepare, load and end steps, plus a division when the
//   window is not a power of two. These steps use the shared bit-serial
//   divider (one quotient bit per cycle) and the shared 16x32 multiplier.
//   s_axis_tready is high only while idle.
//   The output register holds a finished result; a new item is accepted
//   while it waits. If the receiver stalls, the next result waits in the
//   final step until the output register is free.
//   Reset (synchronous, active low) restores register defaults, clears the
//   loop state and the ring (valid bits), and sets the startup counter to 1.
//   The user must write configuration over APB only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module distributed_clock_sync_loop #(
    parameter int AVERAGE_DEPTH = dcsl_pkg::AVERAGE_DEPTH_DEF,
    parameter int DRIFT_WINDOW  = dcsl_pkg::DRIFT_WINDOW_DEF,
    parameter int IGNORE_ITEMS  = dcsl_pkg::IGNORE_ITEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dcsl_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dcsl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dcsl_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [31:0] clock_diff_ns
    input  logic [dcsl_pkg::DIFF_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [30:0] phase_error_ns, [78:31] base_step_ns,
    //        [142:79] time_base_ns, [143] zero pad
    output logic [dcsl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: [0] ignoring
    output logic                             m_axis_tuser
);
    import dcsl_pkg::*;

    // Derived sizes
    localparam int RP_W     = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int AVG_LOG  = $clog2(AVERAGE_DEPTH);
    localparam bit AVG_POW2 = ((AVERAGE_DEPTH & (AVERAGE_DEPTH - 1)) == 0);
    localparam int DR_LOG   = $clog2(DRIFT_WINDOW);
    localparam bit DR_POW2  = ((DRIFT_WINDOW & (DRIFT_WINDOW - 1)) == 0);
    localparam int RSUM_W   = PHASE_W + AVG_LOG;
    localparam int DT_W     = DIFF_W + $clog2(DRIFT_WINDOW);
    localparam int DT1_W    = DT_W + 1;
    localparam int DC_W     = $clog2(DRIFT_WINDOW + 1);
    localparam int IGN_W    = $clog2(IGNORE_ITEMS + 1);
    localparam int HALF_WIN = DRIFT_WINDOW / 2;
    localparam int DW_A     = (RSUM_W > DIFF_W) ? RSUM_W : DIFF_W;
    localparam int DW       = (DT1_W > DW_A) ? DT1_W : DW_A;
    localparam int REM_W    = DIVISOR_W + 1;
    localparam int CNT_W    = $clog2(DW + 1);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [CYCLE_W-1:0]        r_cycle;
    logic [PHASE_W-1:0]        r_target;
    logic signed [GAIN_W-1:0]  r_kp, r_ki, r_kd;

    logic signed [DIFF_W-1:0]  r_last_diff;
    logic signed [DIFF_W-1:0]  r_delta;
    logic                      r_neg;
    logic                      r_ign;
    logic [IGN_W-1:0]          r_ign_cnt;

    logic [PHASE_W-1:0]        r_ring_mem [AVERAGE_DEPTH];
    logic [AVERAGE_DEPTH-1:0]  r_ring_vld;
    logic [PHASE_W-1:0]        r_ring_rd;
    logic                      r_old_vld;
    logic [RP_W-1:0]           r_ring_pos;
    logic [RSUM_W-1:0]         r_ring_sum;
    logic [PHASE_W-1:0]        r_folded;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [DERR_W-1:0]  r_derr;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DT_W-1:0]    r_drift_tot;
    logic [DC_W-1:0]           r_drift_cnt;
    logic signed [DT1_W-1:0]   r_dsum;
    logic                      r_dneg;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [STEP_W-1:0]  r_step;
    logic [BASE_W-1:0]         r_time_base;

    logic [DW-1:0]             r_dq;
    logic [REM_W-1:0]          r_drem;
    logic [DIVISOR_W-1:0]      r_dden;
    logic [CNT_W-1:0]          r_dcnt;

    logic                      r_out_vld;
    logic [ERR_W-1:0]          r_out_err;
    logic [STEP_W-1:0]         r_out_step;
    logic [BASE_W-1:0]         r_out_base;
    logic                      r_out_ign;

    logic                      in_xfer;
    logic                      push_ok;
    logic                      div_run;
    logic                      cfg_wr;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle  <= CYCLE_RST;
            r_target <= TARGET_RST;
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_CYCLE:  r_cycle  <= pwdata[CYCLE_W-1:0];
                REG_TARGET: r_target <= pwdata[PHASE_W-1:0];
                REG_KP:     r_kp     <= pwdata[GAIN_W-1:0];
                REG_KI:     r_ki     <= pwdata[GAIN_W-1:0];
                REG_KD:     r_kd     <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_CYCLE:  prdata = {{(APB_DATA_W-CYCLE_W){1'b0}}, r_cycle};
            REG_TARGET: prdata = {{(APB_DATA_W-PHASE_W){1'b0}}, r_target};
            REG_KP:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_kp};
            REG_KI:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_ki};
            REG_KD:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, r_kd};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_xfer = s_axis_tvalid & s_axis_tready;
    assign push_ok = (r_state == S_PUSH) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic [DC_W-1:0] drift_cnt_inc;
    assign drift_cnt_inc = r_drift_cnt + DC_W'(1);

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_run       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = S_FOLD_RUN;
            end
            S_FOLD_RUN: begin
                div_run = 1'b1;
                if (r_dcnt == CNT_W'(1)) n_state = S_FOLD_END;
            end
            S_FOLD_END: n_state = S_SUM;
            S_SUM:      n_state = AVG_POW2 ? S_ERR : S_AVG_RUN;
            S_AVG_RUN: begin
                div_run = 1'b1;
                if (r_dcnt == CNT_W'(1)) n_state = S_ERR;
            end
            S_ERR: n_state = S_UPD;
            S_UPD: begin
                if (r_ign) begin
                    n_state = S_PUSH;
                end else if (drift_cnt_inc == DC_W'(DRIFT_WINDOW)) begin
                    n_state = S_DR_PREP;
                end else begin
                    n_state = S_MUL_P;
                end
            end
            S_DR_PREP: n_state = S_DR_LOAD;
            S_DR_LOAD: n_state = DR_POW2 ? S_DR_END : S_DR_RUN;
            S_DR_RUN: begin
                div_run = 1'b1;
                if (r_dcnt == CNT_W'(1)) n_state = S_DR_END;
            end
            S_DR_END: n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_I;
            S_MUL_I:  n_state = S_MUL_D;
            S_MUL_D:  n_state = S_ACC;
            S_ACC:    n_state = S_SAT;
            S_SAT:    n_state = S_BASE;
            S_BASE:   n_state = S_PUSH;
            S_PUSH: begin
                if (!r_out_vld || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared bit-serial divider (restoring, one quotient bit per cycle)
    // ------------------------------------------------------------------
    logic [REM_W-1:0]       div_shift;
    logic                   div_ge;
    logic [DIFF_W-1:0]      diff_mag;
    logic [RSUM_W-1:0]      n_ring_sum;
    logic [PHASE_W-1:0]     ring_old;
    logic [DT1_W-1:0]       dsum_mag;

    assign div_shift = {r_drem[REM_W-2:0], r_dq[DW-1]};
    assign div_ge    = (div_shift >= {1'b0, r_dden});
    assign diff_mag  = s_axis_tdata[DIFF_W-1] ? (DIFF_W'(0) - s_axis_tdata) : s_axis_tdata;
    assign ring_old  = r_old_vld ? r_ring_rd : '0;
    assign n_ring_sum = r_ring_sum - RSUM_W'(ring_old) + RSUM_W'(r_folded);
    assign dsum_mag  = r_dsum[DT1_W-1] ? DT1_W'(-r_dsum) : DT1_W'(r_dsum);

    always_ff @(posedge i_clk) begin
        if (div_run) begin
            r_dq   <= {r_dq[DW-2:0], div_ge};
            r_drem <= div_ge ? (div_shift - {1'b0, r_dden}) : div_shift;
            r_dcnt <= r_dcnt - CNT_W'(1);
        end else if (in_xfer) begin
            // Fold: magnitude of the difference over the cycle length
            r_dq   <= DW'(diff_mag) << (DW - DIFF_W);
            r_drem <= '0;
            r_dden <= r_cycle;
            r_dcnt <= CNT_W'(DIFF_W);
        end else if (r_state == S_SUM) begin
            // Average: ring sum over the ring depth
            r_dq   <= DW'(n_ring_sum) << (DW - RSUM_W);
            r_drem <= '0;
            r_dden <= DIVISOR_W'(AVERAGE_DEPTH);
            r_dcnt <= CNT_W'(RSUM_W);
        end else if (r_state == S_DR_LOAD) begin
            // Drift: rounded total over the window, magnitude only
            r_dq   <= DW'(dsum_mag) << (DW - DT1_W);
            r_drem <= '0;
            r_dden <= DIVISOR_W'(DRIFT_WINDOW);
            r_dcnt <= CNT_W'(DT1_W);
        end
    end

    // ------------------------------------------------------------------
    // Phase ring memory (read at accept, written after the fold)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ring_rd <= r_ring_mem[r_ring_pos];
        end
        if (r_state == S_SUM) begin
            r_ring_mem[r_ring_pos] <= r_folded;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;

    always_comb begin
        unique case (r_state)
            S_MUL_P: begin
                mul_a = r_kp;
                mul_b = DIFF_W'(r_err);
            end
            S_MUL_I: begin
                mul_a = r_ki;
                mul_b = r_integ;
            end
            S_MUL_D: begin
                mul_a = r_kd;
                mul_b = r_derr;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [IGN_W:0]            ign_inc;
    logic [PHASE_W-1:0]        avg_q;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic [ACC_W-1:0]          drift_q;
    logic                      ovf_hi, ovf_lo;
    logic signed [STEP_W-1:0]  step_sat;

    assign ign_inc = {1'b0, r_ign_cnt} + (IGN_W + 1)'(1);
    assign avg_q   = AVG_POW2 ? PHASE_W'(r_ring_sum >> AVG_LOG) : r_dq[PHASE_W-1:0];
    assign n_err   = $signed({1'b0, avg_q}) - $signed({1'b0, r_target});

    assign integ_sum = (INTEG_W + 1)'(r_integ) + (INTEG_W + 1)'(r_err);
    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // Power-of-two window: shift the rounded magnitude, else take the quotient
    assign drift_q = DR_POW2 ? ACC_W'(dsum_mag >> DR_LOG) : ACC_W'(r_dq);

    assign ovf_hi = ~r_acc[ACC_W-1] & (|r_acc[ACC_W-2:STEP_W-1]);
    assign ovf_lo = r_acc[ACC_W-1] & ~(&r_acc[ACC_W-2:STEP_W-1]);
    always_comb begin
        if (ovf_hi) begin
            step_sat = {1'b0, {(STEP_W-1){1'b1}}};
        end else if (ovf_lo) begin
            step_sat = {1'b1, {(STEP_W-1){1'b0}}};
        end else begin
            step_sat = r_acc[STEP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Loop state with reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_diff <= '0;
            r_ign_cnt   <= IGN_W'(1);
            r_ring_vld  <= '0;
            r_ring_pos  <= '0;
            r_ring_sum  <= '0;
            r_last_err  <= '0;
            r_integ     <= '0;
            r_drift_tot <= '0;
            r_drift_cnt <= '0;
            r_time_base <= '0;
        end else begin
            // Latch the difference and advance the startup counter
            if (in_xfer) begin
                r_last_diff <= s_axis_tdata;
                if (r_ign_cnt != '0) begin
                    r_ign_cnt <= (ign_inc >= (IGN_W + 1)'(IGNORE_ITEMS))
                               ? '0 : ign_inc[IGN_W-1:0];
                end
            end
            // Replace the oldest ring sample
            if (r_state == S_SUM) begin
                r_ring_sum             <= n_ring_sum;
                r_ring_vld[r_ring_pos] <= 1'b1;
                r_ring_pos <= (r_ring_pos == RP_W'(AVERAGE_DEPTH - 1))
                            ? '0 : r_ring_pos + RP_W'(1);
            end
            // Error history, drift and integral
            if (r_state == S_UPD) begin
                r_last_err <= r_err;
                if (!r_ign) begin
                    r_drift_tot <= r_drift_tot + DT_W'(r_delta);
                    r_drift_cnt <= drift_cnt_inc;
                    r_integ     <= integ_sat;
                end
            end
            // Clear the drift window once its total is taken
            if (r_state == S_DR_PREP) begin
                r_drift_tot <= '0;
                r_drift_cnt <= '0;
            end
            if (r_state == S_BASE) begin
                r_time_base <= r_time_base + BASE_W'(r_step);
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-item working registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_delta   <= s_axis_tdata - r_last_diff;
            r_neg     <= s_axis_tdata[DIFF_W-1];
            r_ign     <= (r_ign_cnt != '0);
            r_old_vld <= r_ring_vld[r_ring_pos];
        end
        // Folded phase: zero for a zero cycle, else remainder, or cycle minus remainder when negative
        if (r_state == S_FOLD_END) begin
            if (r_cycle == '0) begin
                r_folded <= '0;
            end else if (r_neg) begin
                r_folded <= r_cycle - r_drem[PHASE_W-1:0];
            end else begin
                r_folded <= r_drem[PHASE_W-1:0];
            end
        end
        if (r_state == S_ERR) begin
            r_err <= n_err;
        end
        if (r_state == S_UPD) begin
            r_derr <= DERR_W'(r_err) - DERR_W'(r_last_err);
            r_acc  <= '0;
            if (r_ign) r_step <= '0;
        end
        if (r_state == S_DR_PREP) begin
            r_dsum <= DT1_W'(r_drift_tot) + DT1_W'(HALF_WIN);
        end
        if (r_state == S_DR_LOAD) begin
            r_dneg <= r_dsum[DT1_W-1];
        end
        if (r_state == S_DR_END) begin
            r_acc <= r_dneg ? -$signed(drift_q) : $signed(drift_q);
        end
        // Multiply into a registered product, then accumulate it in the next step
        r_prod <= mul_a * mul_b;
        if (r_state == S_MUL_I || r_state == S_MUL_D || r_state == S_ACC) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_SAT) begin
            r_step <= step_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push_ok) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_out_err  <= r_err;
            r_out_step <= r_step;
            r_out_base <= r_time_base;
            r_out_ign  <= r_ign;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_base, r_out_step, r_out_err};
    assign m_axis_tuser  = r_out_ign;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_accept_starts_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_FOLD_RUN))
        else $error("accepted item did not start the fold division");

    a_ignored_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out_ign || (r_out_step == '0)))
        else $error("ignored item carries a nonzero base step");

    a_div_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_run |-> ((r_dcnt != '0) && (r_dcnt <= CNT_W'(DW))))
        else $error("divider iteration count out of range");

    a_ign_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ign_cnt} < (IGN_W + 1)'(IGNORE_ITEMS)))
        else $error("startup counter reached its limit");

    a_ring_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((RP_W + 1)'(r_ring_pos) < (RP_W + 1)'(AVERAGE_DEPTH)))
        else $error("ring position beyond ring depth");
`endif

endmodule
